// ===== hdl/kli_pkg.sv =====
// shared types and constants for the keyframe linear interpolator
// no dependencies
`timescale 1ns / 1ps
package kli_pkg;
	localparam int MaxKeys = 64;
	localparam int IdxW = $clog2(MaxKeys);
	localparam int CntW = 7;

	typedef struct packed {
		logic start;
		logic seg_found;
		logic load_t;
		logic load_v;
		logic div_start;
	} kli_cmd_t;

	typedef struct packed {
		logic done;
		logic stop;
		logic div_done;
		logic single;
	} kli_sts_t;

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_SRCH   = 9'b000000010,
		ST_SWAIT  = 9'b000000100,
		ST_RDT    = 9'b000001000,
		ST_RDW    = 9'b000010000,
		ST_DIV    = 9'b000100000,
		ST_MUL    = 9'b001000000,
		ST_SUM    = 9'b010000000,
		ST_OUT    = 9'b100000000
	} kli_state_t;
endpackage

// ===== hdl/kli_ram.sv =====
// generic single-write, one-read ram with registered read
// no dependencies
`timescale 1ns / 1ps
module kli_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== hdl/kli_datapath.sv =====
// datapath: key tables, segment search, serial divider, multiply and saturate
// depends on kli_pkg and kli_ram
`timescale 1ns / 1ps
module kli_datapath import kli_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  kli_cmd_t              cmd,
	output kli_sts_t              sts,
	input  logic                  ld_we,
	input  logic [IdxW-1:0]       ld_idx,
	input  logic [31:0]           ld_time,
	input  logic [95:0]           ld_val,
	input  logic [31:0]           qtime,
	input  logic [CntW-1:0]       key_count,
	input  logic                  st_srch,
	input  logic                  st_rdt,
	input  logic                  st_rdw,
	input  logic                  st_mul,
	input  logic                  st_sum,
	output logic [95:0]           res_val,
	output logic [IdxW-1:0]       res_seg,
	output logic                  res_sat
);
	logic [IdxW-1:0] raddr, seg_q, ptr_q;
	logic [31:0] trd;
	logic [95:0] vrd;
	logic [31:0] t_q, t0_q;
	logic [CntW-1:0] n_eff, lim;
	logic [95:0] vs_q;
	logic [5:0] divcnt_q;
	logic [48:0] rem_q;
	logic [47:0] quo_q;
	logic [47:0] dividend_q;
	logic [32:0] divisor_q;
	logic neg_q, zero_q, fsat_q;
	logic [31:0] fac_q;
	logic signed [65:0] prod_s1 [3];
	logic signed [49:0] sum_res [3];
	logic [95:0] res_q;
	logic sat_q;
	logic [95:0] res_c;
	logic sat_c;

	kli_ram #(.Width(32), .Depth(MaxKeys)) u_tram (
		.clk(clk), .we(ld_we), .waddr(ld_idx), .wdata(ld_time), .raddr(raddr), .rdata(trd));
	kli_ram #(.Width(96), .Depth(MaxKeys)) u_vram (
		.clk(clk), .we(ld_we), .waddr(ld_idx), .wdata(ld_val), .raddr(raddr), .rdata(vrd));

	always_comb begin
		n_eff = key_count;
		if (key_count == '0) n_eff = CntW'(1);
		if (key_count > CntW'(MaxKeys)) n_eff = CntW'(MaxKeys);
		lim = n_eff - CntW'(2);
	end

	assign sts.single = (n_eff < CntW'(2));
	// search reads entry ptr+1, the tested next time
	assign sts.stop = ({1'b0, ptr_q} >= lim) || (trd >= t_q);
	assign sts.div_done = (divcnt_q == '0);
	assign sts.done = 1'b0;

	always_comb begin
		raddr = ptr_q + IdxW'(1);
		if (st_srch) raddr = ptr_q + IdxW'(2);
		if (st_rdt) raddr = ptr_q;
		if (st_rdw) raddr = seg_q + IdxW'(1);
		if (cmd.start) raddr = IdxW'(1);
	end

	logic [32:0] dt;
	logic [32:0] nt;
	logic [48:0] rem_sh;
	assign dt = {1'b0, trd} - {1'b0, t0_q};
	assign nt = {1'b0, t_q} - {1'b0, t0_q};
	assign rem_sh = {rem_q[47:0], dividend_q[47]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			seg_q <= '0;
			divcnt_q <= '0;
		end else begin
			if (cmd.start) begin
				ptr_q <= '0;
				t_q <= qtime;
			end else if (st_srch && !sts.stop) begin
				ptr_q <= ptr_q + IdxW'(1);
			end
			if (cmd.seg_found) seg_q <= sts.single ? '0 : ptr_q;
			if (cmd.load_t) t0_q <= trd;
			if (cmd.load_v) vs_q <= vrd;
			if (cmd.div_start) begin
				zero_q <= (dt == '0);
				neg_q <= nt[32] ^ dt[32];
				dividend_q <= {(nt[32] ? -nt[31:0] : nt[31:0]), 16'h0};
				divisor_q <= dt[32] ? -dt : dt;
				rem_q <= '0;
				quo_q <= '0;
				divcnt_q <= 6'd48;
			end else if (divcnt_q != '0) begin
				dividend_q <= {dividend_q[46:0], 1'b0};
				if (rem_sh >= {16'h0, divisor_q}) begin
					rem_q <= rem_sh - {16'h0, divisor_q};
					quo_q <= {quo_q[46:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[46:0], 1'b0};
				end
				divcnt_q <= divcnt_q - 6'd1;
			end
		end
	end

	// signed factor with saturation
	logic [31:0] fac_c;
	logic fsat_c;
	always_comb begin
		fsat_c = 1'b0;
		if (zero_q) begin
			fac_c = '0;
		end else if (!neg_q) begin
			if (quo_q > 48'h7FFFFFFF) begin
				fac_c = 32'h7FFFFFFF; fsat_c = 1'b1;
			end else fac_c = quo_q[31:0];
		end else begin
			if (quo_q > 48'h80000000) begin
				fac_c = 32'h80000000; fsat_c = 1'b1;
			end else fac_c = 32'(-quo_q);
		end
	end

	always_ff @(posedge clk) begin
		if (sts.div_done && !cmd.div_start) begin
			fac_q <= fac_c;
			fsat_q <= fsat_c;
		end
		for (int a = 0; a < 3; a++) begin
			if (st_mul) begin
				prod_s1[a] <= $signed(fac_q) * ($signed({vrd[a*32+31], vrd[a*32 +: 32]})
					- $signed({vs_q[a*32+31], vs_q[a*32 +: 32]}));
			end
		end
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			sum_res[a] = 50'($signed(vs_q[a*32 +: 32]))
				+ 50'((prod_s1[a] + 66'sd32768) >>> 16);
		end
	end

	always_comb begin
		res_c = vs_q;
		sat_c = fsat_q && !sts.single;
		if (!sts.single) begin
			for (int a = 0; a < 3; a++) begin
				if (sum_res[a] > 50'sh7FFFFFFF) begin
					res_c[a*32 +: 32] = 32'h7FFFFFFF;
					sat_c = 1'b1;
				end else if (sum_res[a] < -50'sh80000000) begin
					res_c[a*32 +: 32] = 32'h80000000;
					sat_c = 1'b1;
				end else begin
					res_c[a*32 +: 32] = sum_res[a][31:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_sum) begin
			res_q <= res_c;
			sat_q <= sat_c;
		end
	end

	assign res_val = res_q;
	assign res_seg = seg_q;
	assign res_sat = sat_q;
endmodule

// ===== hdl/kli_ctrl.sv =====
// controller state machine for queries
// depends on kli_pkg
`timescale 1ns / 1ps
module kli_ctrl import kli_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_fire,
	input  logic     in_query,
	input  logic     out_fire,
	input  kli_sts_t sts,
	output kli_cmd_t cmd,
	output logic     busy,
	output logic     res_valid,
	output logic     st_srch,
	output logic     st_rdt,
	output logic     st_rdw,
	output logic     st_mul,
	output logic     st_sum
);
	kli_state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.start = in_fire && in_query;
		unique case (state_q)
			ST_IDLE:  if (in_fire && in_query) state_d = ST_SWAIT;
			ST_SWAIT: state_d = ST_SRCH;
			ST_SRCH:  if (sts.stop || sts.single) begin
				cmd.seg_found = 1'b1;
				state_d = ST_RDT;
			end
			ST_RDT: begin
				cmd.load_t = 1'b1;
				cmd.load_v = 1'b1;
				state_d = ST_RDW;
			end
			ST_RDW: begin
				cmd.div_start = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV:   if (sts.div_done) state_d = ST_MUL;
			ST_MUL:   state_d = ST_SUM;
			ST_SUM:   state_d = ST_OUT;
			ST_OUT:   if (out_fire) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	assign busy = (state_q != ST_IDLE);
	assign res_valid = (state_q == ST_OUT);
	assign st_srch = (state_q == ST_SRCH);
	assign st_rdt = (state_q == ST_SRCH) && (sts.stop || sts.single);
	assign st_rdw = (state_q == ST_RDT);
	assign st_mul = (state_q == ST_MUL);
	assign st_sum = (state_q == ST_SUM);

`ifndef SYNTHESIS
	a_out_from_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) && !$past(state_q == ST_OUT) |-> $past(state_q == ST_SUM))
		else $error("result without sum");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) && !out_fire |=> (state_q == ST_OUT))
		else $error("result dropped");
	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> (state_q == ST_DIV))
		else $error("divider not started");
`endif
endmodule

// ===== hdl/keyframe_linear_interpolator_unit.sv =====
// Keyframe linear interpolator. A load (tuser 0) writes one entry and returns
// nothing. A query (tuser 1) passes a wait state, a linear search reading one
// key time a cycle from the time ram, two table reads, a 48-step restoring
// divider for the Q16.16 factor, one multiply and one round-and-saturate step,
// then raises its result. The next item is taken in the cycle after the result
// transfer. One item is worked on at a time.
// depends on kli_pkg, kli_ctrl, kli_datapath
`timescale 1ns / 1ps
module keyframe_linear_interpolator_unit import kli_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// key_index[5:0], key_time[37:6], key_x[69:38], key_y[101:70],
	// key_z[133:102], query_time[165:134], zero fill
	input  logic [167:0] s_axis_tdata,
	// kind
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// out_x[31:0], out_y[63:32], out_z[95:64], segment[101:96], saturated[102], zero fill
	output logic [103:0] m_axis_tdata,
	input  logic         cfg_we,
	input  logic [6:0]   cfg_wdata
);
	logic [CntW-1:0] key_count_q;
	kli_cmd_t cmd;
	kli_sts_t sts;
	logic busy, res_valid, in_fire, out_fire;
	logic st_srch, st_rdt, st_rdw, st_mul, st_sum;
	logic [95:0] res_val;
	logic [IdxW-1:0] res_seg;
	logic res_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) key_count_q <= CntW'(2);
		else if (cfg_we) key_count_q <= cfg_wdata;
	end

	assign s_axis_tready = !busy;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;

	kli_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_query(s_axis_tuser),
		.out_fire(out_fire), .sts(sts), .cmd(cmd), .busy(busy), .res_valid(res_valid),
		.st_srch(st_srch), .st_rdt(st_rdt), .st_rdw(st_rdw), .st_mul(st_mul),
		.st_sum(st_sum));

	kli_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.ld_we(in_fire && !s_axis_tuser), .ld_idx(s_axis_tdata[5:0]),
		.ld_time(s_axis_tdata[37:6]), .ld_val(s_axis_tdata[133:38]),
		.qtime(s_axis_tdata[165:134]), .key_count(key_count_q),
		.st_srch(st_srch), .st_rdt(st_rdt), .st_rdw(st_rdw), .st_mul(st_mul),
		.st_sum(st_sum), .res_val(res_val), .res_seg(res_seg), .res_sat(res_sat));

	assign m_axis_tvalid = res_valid;
	assign m_axis_tdata = {1'b0, res_sat, res_seg, res_val};
endmodule
